/* design/srs_pkg.sv */
`timescale 1ns / 1ps

package srs_pkg;

    // Widths of the fixed-point fields.
    localparam int SAMPLE_W = 32;
    localparam int SCORE_W  = 32;
    localparam int MARGIN_W = 31;
    localparam int SUM_W    = 46;
    localparam int STEP_W   = $clog2(SUM_W);

    // Saturation limit of the error accumulator and the penalty score (10000.0 in Q16.16).
    localparam logic [SUM_W-1:0]   SUM_MAX     = {SUM_W{1'b1}};
    localparam logic [SCORE_W-1:0] PENALTY_Q16 = 32'd655360000;

    // Reset values of the configuration registers.
    localparam logic signed [SAMPLE_W-1:0] REFERENCE_RST   = 32'sd0;
    localparam logic signed [SAMPLE_W-1:0] UPPER_BOUND_RST = 32'sd6554;
    localparam logic signed [SAMPLE_W-1:0] LOWER_BOUND_RST = -32'sd1310720;
    localparam logic [MARGIN_W-1:0]        MARGIN_RST      = 31'd720896;

    // Configuration register indexes.
    typedef enum logic [1:0] {
        REG_REFERENCE        = 2'd0,
        REG_UPPER_BOUND      = 2'd1,
        REG_LOWER_BOUND      = 2'd2,
        REG_OVERSHOOT_MARGIN = 2'd3
    } cfg_index_t;

    // Run verdict codes.
    typedef enum logic [1:0] {
        VERDICT_OK        = 2'd0,
        VERDICT_BOUND     = 2'd1,
        VERDICT_OVERSHOOT = 2'd2
    } verdict_t;

    // Sequencer states.
    typedef enum logic [1:0] {
        ST_IDLE,
        ST_DIVIDE,
        ST_FINISH
    } state_t;

    typedef logic signed [SAMPLE_W-1:0] sample_t;
    typedef logic [SCORE_W-1:0]         score_t;

endpackage

/* design/srs_if.sv */
`timescale 1ns / 1ps

// Sample stream: one response sample per transaction.
interface srs_sample_if;
    import srs_pkg::*;

    logic    valid;
    logic    ready;
    sample_t sample;
    logic    last_sample;

    modport source (output valid, output sample, output last_sample, input ready);
    modport sink   (input valid, input sample, input last_sample, output ready);
endinterface

// Result stream: one score per finished run.
interface srs_score_if;
    import srs_pkg::*;

    logic     valid;
    logic     ready;
    score_t   score;
    verdict_t verdict;

    modport source (output valid, output score, output verdict, input ready);
    modport sink   (input valid, input score, input verdict, output ready);
endinterface

// Configuration write channel.
interface srs_cfg_if;
    import srs_pkg::*;

    logic       valid;
    logic       ready;
    cfg_index_t index;
    logic [SAMPLE_W-1:0] data;

    modport source (output valid, output index, output data, input ready);
    modport sink   (input valid, input index, input data, output ready);
endinterface

/* design/step_response_scorer_core.sv */
`timescale 1ns / 1ps

// Step response scorer.
// The samples channel takes one signed Q16.16 sample per transaction, with
// last_sample set on the final sample of a run. A non-last sample leaves
// the block idle, so it is ready again in the next cycle. The last
// sample starts the scoring: a one-bit-per-cycle restoring divider
// forms the mean absolute error, then the finish state checks the bound
// window and the overshoot and loads the result register. After a run's
// last sample the samples channel is not ready until the result register
// is loaded.
// The scores channel presents score and verdict from an output register. When
// the receiver stalls, the result holds and the block keeps taking samples
// of the next run; once that run's last sample is taken and its mean is
// formed, the block stays busy until the held result is taken.
// The cfg channel is always ready and should only be written while the block
// is idle. Reset sets the cfg registers to defaults and opens an empty run.
module step_response_scorer_core #(
    parameter int MAX_RUN_LENGTH = 4096
) (
    input  logic          clk,
    input  logic          rst_n,
    srs_cfg_if.sink       cfg,
    srs_sample_if.sink    samples,
    srs_score_if.source   scores
);
    import srs_pkg::*;

    localparam int CNT_W = $clog2(MAX_RUN_LENGTH + 1);
    localparam logic [CNT_W-1:0] RUN_LIMIT = CNT_W'(MAX_RUN_LENGTH);

    // Configuration registers.
    sample_t               reference_reg;
    sample_t               upper_bound_reg;
    sample_t               lower_bound_reg;
    logic [MARGIN_W-1:0]   margin_reg;

    // Run state.
    state_t                state_reg, state_next;
    sample_t               first_reg, first_next;
    logic                  have_first_reg, have_first_next;
    sample_t               max_reg, max_next;
    sample_t               min_reg, min_next;
    logic [SUM_W-1:0]      sum_reg, sum_next;
    logic [CNT_W-1:0]      count_reg, count_next;
    logic [CNT_W-1:0]      rem_reg, rem_next;
    logic [STEP_W-1:0]     step_reg, step_next;

    // Output register.
    logic                  out_valid_reg, out_valid_next;
    score_t                score_reg, score_next;
    verdict_t              verdict_reg, verdict_next;

    // Datapath intermediates.
    logic                  sample_take;
    logic                  out_free;
    sample_t               base_max;
    sample_t               base_min;
    logic signed [SAMPLE_W:0] diff;
    logic [SAMPLE_W-1:0]   abs_diff;
    logic [SUM_W:0]        sum_add;
    logic [CNT_W:0]        trial;
    logic                  trial_ge;
    logic signed [SAMPLE_W+1:0] ref_plus;
    logic signed [SAMPLE_W+1:0] ref_minus;
    verdict_t              verdict_calc;
    score_t                mean_sat;

    assign cfg.ready      = 1'b1;
    assign samples.ready  = (state_reg == ST_IDLE);
    assign sample_take    = samples.valid && samples.ready;
    assign out_free       = !out_valid_reg || scores.ready;

    assign scores.valid   = out_valid_reg;
    assign scores.score   = score_reg;
    assign scores.verdict = verdict_reg;

    // Configuration writes.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            reference_reg   <= REFERENCE_RST;
            upper_bound_reg <= UPPER_BOUND_RST;
            lower_bound_reg <= LOWER_BOUND_RST;
            margin_reg      <= MARGIN_RST;
        end
        else if (cfg.valid && cfg.ready)
        begin
            unique case (cfg.index)
                REG_REFERENCE:        reference_reg   <= cfg.data;
                REG_UPPER_BOUND:      upper_bound_reg <= cfg.data;
                REG_LOWER_BOUND:      lower_bound_reg <= cfg.data;
                REG_OVERSHOOT_MARGIN: margin_reg      <= cfg.data[MARGIN_W-1:0];
                default:              ;
            endcase
        end
    end

    // Sequencer next state.
    always_comb
    begin
        state_next = state_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_take && samples.last_sample)
                begin
                    state_next = ST_DIVIDE;
                end
            end
            ST_DIVIDE:
            begin
                if (step_reg == STEP_W'(SUM_W - 1))
                begin
                    state_next = ST_FINISH;
                end
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    state_next = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    // Sample accumulation terms.
    always_comb
    begin
        base_max = have_first_reg ? max_reg : samples.sample;
        base_min = have_first_reg ? min_reg : samples.sample;
        diff     = {samples.sample[SAMPLE_W-1], samples.sample}
                 - {reference_reg[SAMPLE_W-1], reference_reg};
        abs_diff = diff[SAMPLE_W] ? SAMPLE_W'(-diff) : diff[SAMPLE_W-1:0];
        sum_add  = {1'b0, sum_reg} + {{(SUM_W + 1 - SAMPLE_W){1'b0}}, abs_diff};
    end

    // Divider step: one quotient bit per cycle, shifted into the sum register.
    always_comb
    begin
        trial    = {rem_reg, sum_reg[SUM_W-1]};
        trial_ge = (trial >= {1'b0, count_reg});
    end

    // Verdict and saturated mean from the finished run.
    always_comb
    begin
        ref_plus  = {{2{reference_reg[SAMPLE_W-1]}}, reference_reg}
                  + {3'b000, margin_reg};
        ref_minus = {{2{reference_reg[SAMPLE_W-1]}}, reference_reg}
                  - {3'b000, margin_reg};
        mean_sat  = (|sum_reg[SUM_W-1:SCORE_W]) ? {SCORE_W{1'b1}}
                                                 : sum_reg[SCORE_W-1:0];
        verdict_calc = VERDICT_OK;
        if (max_reg > upper_bound_reg || min_reg < lower_bound_reg)
        begin
            verdict_calc = VERDICT_BOUND;
        end
        else if (reference_reg > first_reg)
        begin
            if ($signed({{2{max_reg[SAMPLE_W-1]}}, max_reg}) > ref_plus)
            begin
                verdict_calc = VERDICT_OVERSHOOT;
            end
        end
        else if ($signed({{2{min_reg[SAMPLE_W-1]}}, min_reg}) < ref_minus)
        begin
            verdict_calc = VERDICT_OVERSHOOT;
        end
    end

    // Sequencer outputs and datapath register updates.
    always_comb
    begin
        first_next      = first_reg;
        have_first_next = have_first_reg;
        max_next        = max_reg;
        min_next        = min_reg;
        sum_next        = sum_reg;
        count_next      = count_reg;
        rem_next        = rem_reg;
        step_next       = step_reg;
        out_valid_next  = out_valid_reg && !scores.ready;
        score_next      = score_reg;
        verdict_next    = verdict_reg;

        unique case (state_reg)
            ST_IDLE:
            begin
                if (sample_take)
                begin
                    if (!have_first_reg)
                    begin
                        first_next = samples.sample;
                    end
                    have_first_next = 1'b1;
                    max_next = (samples.sample > base_max) ? samples.sample : base_max;
                    min_next = (samples.sample < base_min) ? samples.sample : base_min;
                    if (count_reg < RUN_LIMIT)
                    begin
                        sum_next   = sum_add[SUM_W] ? SUM_MAX : sum_add[SUM_W-1:0];
                        count_next = count_reg + 1'b1;
                    end
                    rem_next  = '0;
                    step_next = '0;
                end
            end
            ST_DIVIDE:
            begin
                rem_next  = trial_ge ? CNT_W'(trial - {1'b0, count_reg})
                                     : trial[CNT_W-1:0];
                sum_next  = {sum_reg[SUM_W-2:0], trial_ge};
                step_next = step_reg + 1'b1;
            end
            ST_FINISH:
            begin
                if (out_free)
                begin
                    out_valid_next  = 1'b1;
                    verdict_next    = verdict_calc;
                    score_next      = (verdict_calc == VERDICT_OK) ? mean_sat : PENALTY_Q16;
                    first_next      = '0;
                    have_first_next = 1'b0;
                    max_next        = '0;
                    min_next        = '0;
                    sum_next        = '0;
                    count_next      = '0;
                end
            end
            default: ;
        endcase
    end

    // Control registers.
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= ST_IDLE;
            have_first_reg <= 1'b0;
            first_reg      <= '0;
            max_reg        <= '0;
            min_reg        <= '0;
            sum_reg        <= '0;
            count_reg      <= '0;
            step_reg       <= '0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            have_first_reg <= have_first_next;
            first_reg      <= first_next;
            max_reg        <= max_next;
            min_reg        <= min_next;
            sum_reg        <= sum_next;
            count_reg      <= count_next;
            step_reg       <= step_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers.
    always_ff @(posedge clk)
    begin
        rem_reg     <= rem_next;
        score_reg   <= score_next;
        verdict_reg <= verdict_next;
    end

endmodule
